/* hw/rtl/softmax_linear_classifier_macros.svh */
// Assertion macros for the softmax linear classifier.
// Used by the controller and the top level.
`ifndef SOFTMAX_LINEAR_CLASSIFIER_MACROS_SVH
`define SOFTMAX_LINEAR_CLASSIFIER_MACROS_SVH
// implication checked every clock, quiet during reset
`define SLC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication checked on the next clock
`define SLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* hw/rtl/slc_pkg.sv */
// Shared types and constants for the softmax linear classifier.
// No dependencies.
`timescale 1ns / 1ps
package slc_pkg;
   localparam int FEATURES_DEFAULT = 64;
   localparam int CLASSES_DEFAULT  = 8;
   localparam int MAX_REPORT       = 8;
   localparam int SCORE_W          = 40;
   localparam int EXP_W            = 17;
   localparam int SUM_W            = 20;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;

   // datapath commands
   typedef enum logic [2:0] {
      OP_NONE, OP_MAC, OP_MAX, OP_EXP, OP_DIV_START, OP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [5:0] cls;
      logic       first;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

   function automatic logic [16:0] pow2_lookup(input logic [4:0] idx);
      logic [16:0] r;
      case (idx)
         5'd0: r = 17'd65536;  5'd1: r = 17'd62757;  5'd2: r = 17'd60097;
         5'd3: r = 17'd57549;  5'd4: r = 17'd55109;  5'd5: r = 17'd52773;
         5'd6: r = 17'd50535;  5'd7: r = 17'd48393;  5'd8: r = 17'd46341;
         5'd9: r = 17'd44376;  5'd10: r = 17'd42495; 5'd11: r = 17'd40693;
         5'd12: r = 17'd38968; 5'd13: r = 17'd37316; 5'd14: r = 17'd35734;
         5'd15: r = 17'd34219; default: r = 17'd32768;
      endcase
      return r;
   endfunction
endpackage

/* hw/rtl/slc_datapath.sv */
// Datapath: weight memory, shared multiplier, score bank, exp and divider.
// Depends on slc_pkg.
`timescale 1ns / 1ps
module slc_datapath #(
   parameter int FEATURES = slc_pkg::FEATURES_DEFAULT,
   parameter int CLASSES  = slc_pkg::CLASSES_DEFAULT,
   localparam int CW = (CLASSES > 1) ? $clog2(CLASSES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic                  load,
   input  logic [8:0]            wr_addr,
   input  logic [8:0]            feat,
   input  logic signed [15:0]    value,
   input  slc_pkg::dp_cmd_type   cmd,
   output slc_pkg::dp_status_type status,
   output logic [15:0]           probability
);
   localparam int SW = slc_pkg::SCORE_W;

   logic [15:0] weight_mem [512];
   logic signed [15:0] wrd_ff;
   logic signed [15:0] feat_ff;
   logic [8:0]  pos_ff;
   logic signed [SW-1:0] scores_ff [CLASSES];
   logic signed [SW-1:0] best_ff;
   logic [16:0] expv_ff [CLASSES];
   logic [19:0] sum_ff;
   logic        mac_vld_ff;
   logic [CW-1:0] mac_cls_ff;
   logic signed [31:0] prod_ff;
   logic        prod_vld_ff;
   logic [CW-1:0] prod_cls_ff;
   logic        exp_vld_ff;
   logic        exp_first_ff;
   logic [CW-1:0] exp_cls_ff;
   logic [24:0] u_ff;
   logic [CW-1:0] cidx;
   logic [8:0]  rd_addr;
   logic [31:0] dprod;
   logic [SW-1:0] diff;
   logic [63:0] uprod;
   logic [16:0] ecalc;
   logic [24:0] u;
   logic [32:0] dnum;
   logic [20:0] dpart;
   logic [20:0] dsub;
   logic [20:0] rem_ff;
   logic [16:0] num_ff;
   logic [16:0] quo_ff;
   logic [4:0]  dcnt_ff;
   logic        dbusy_ff;

   assign cidx = cmd.cls[CW-1:0];
   assign rd_addr = 9'((cmd.cls * FEATURES) + pos_ff);

   // weight read, registered; feature held for the whole MAC pass
   always_ff @(posedge clock) begin
      if (wr_en) weight_mem[wr_addr] <= value;
      wrd_ff <= weight_mem[rd_addr];
      if (load) begin
         feat_ff <= value;
         pos_ff <= feat;
      end
   end

   // exp(-d), first stage: d*log2e >> 24
   always_comb begin
      diff  = best_ff - scores_ff[cidx];
      uprod = 64'(diff) * 64'(slc_pkg::LOG2E_Q16);
      u     = (uprod[63:49] != 15'd0) ? '1 : uprod[48:24];
   end

   // exp(-d), second stage: table interpolation and shift
   always_comb begin
      logic [3:0]  ti;
      logic [11:0] fl;
      logic [16:0] t0, t1, m;
      logic [28:0] dt;
      ti = u_ff[15:12];
      fl = u_ff[11:0];
      t0 = slc_pkg::pow2_lookup({1'b0, ti});
      t1 = slc_pkg::pow2_lookup(5'({1'b0, ti} + 5'd1));
      dt = 29'(t0 - t1) * 29'(fl);
      m  = t0 - 17'(dt >> 12);
      ecalc = (u_ff[24:16] >= 9'd17) ? 17'd0 : (m >> u_ff[20:16]);
   end

   assign dprod = 32'(feat_ff * wrd_ff);

   // rounded numerator e*2^16 + sum/2; quotient fits in 17 bits
   assign dnum  = {expv_ff[cidx], 16'd0} + 33'(sum_ff >> 1);
   assign dpart = {rem_ff[19:0], num_ff[16]};
   assign dsub  = dpart - {1'b0, sum_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         exp_vld_ff <= 1'b0;
         dbusy_ff <= 1'b0;
         sum_ff <= '0;
         for (int i = 0; i < CLASSES; i++) begin
            scores_ff[i] <= '0;
            expv_ff[i] <= '0;
         end
      end else begin
         mac_vld_ff <= (cmd.op == slc_pkg::OP_MAC);
         mac_cls_ff <= cidx;
         prod_vld_ff <= mac_vld_ff;
         prod_cls_ff <= mac_cls_ff;
         prod_ff <= dprod;
         if (prod_vld_ff)
            scores_ff[prod_cls_ff] <= scores_ff[prod_cls_ff] + SW'(prod_ff);
         exp_vld_ff <= (cmd.op == slc_pkg::OP_EXP);
         exp_cls_ff <= cidx;
         exp_first_ff <= cmd.first;
         u_ff <= u;
         if (exp_vld_ff) begin
            expv_ff[exp_cls_ff] <= ecalc;
            if (exp_first_ff) sum_ff <= 20'(ecalc);
            else if (21'(sum_ff) + 21'(ecalc) > 21'hFFFFF) sum_ff <= '1;
            else sum_ff <= sum_ff + 20'(ecalc);
         end
         unique case (cmd.op)
            slc_pkg::OP_MAX: begin
               if (cmd.first || scores_ff[cidx] > best_ff) best_ff <= scores_ff[cidx];
            end
            slc_pkg::OP_DIV_START: begin
               rem_ff <= 21'(dnum[32:17]);
               num_ff <= dnum[16:0];
               quo_ff <= '0;
               dcnt_ff <= 5'd0;
               dbusy_ff <= 1'b1;
            end
            slc_pkg::OP_CLEAR: begin
               for (int i = 0; i < CLASSES; i++) scores_ff[i] <= '0;
            end
            default: ;
         endcase
         // restoring divider, one quotient bit per cycle, 17 quotient bits
         if (dbusy_ff) begin
            if (dpart >= {1'b0, sum_ff} && sum_ff != '0) begin
               rem_ff <= dsub;
               quo_ff <= {quo_ff[15:0], 1'b1};
            end else begin
               rem_ff <= dpart;
               quo_ff <= {quo_ff[15:0], 1'b0};
            end
            num_ff <= {num_ff[15:0], 1'b0};
            dcnt_ff <= dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd16) dbusy_ff <= 1'b0;
         end
      end
   end

   assign status.div_done = dbusy_ff && dcnt_ff == 5'd16;
   assign probability = (quo_ff[16] ? 16'hFFFF : quo_ff[15:0]);
endmodule

/* hw/rtl/slc_controller.sv */
// Controller sequencing MAC, max, exp and divide phases.
// Depends on slc_pkg and the macros header.
`timescale 1ns / 1ps
`include "softmax_linear_classifier_macros.svh"
module slc_controller #(
   parameter int FEATURES = slc_pkg::FEATURES_DEFAULT,
   parameter int CLASSES  = slc_pkg::CLASSES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   mode,
   input  logic [8:0]             position,
   input  logic                   final_feature,
   input  slc_pkg::dp_status_type status,
   output slc_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_class,
   output logic                   rsp_last
);
   localparam int NREP = (CLASSES < slc_pkg::MAX_REPORT) ? CLASSES : slc_pkg::MAX_REPORT;
   typedef enum logic [3:0] {
      S_IDLE, S_MAC, S_DRAIN, S_MAX, S_EXP, S_EXPW, S_DIV, S_WAIT, S_CLR
   } state_type;
   state_type state_ff;
   logic [5:0] cls_ff;
   logic fin_ff;

   always_comb begin
      cmd.op = slc_pkg::OP_NONE;
      cmd.cls = cls_ff;
      cmd.first = (cls_ff == 6'd0);
      unique case (state_ff)
         S_MAC: cmd.op = slc_pkg::OP_MAC;
         S_MAX: cmd.op = slc_pkg::OP_MAX;
         S_EXP: cmd.op = slc_pkg::OP_EXP;
         S_DIV: cmd.op = slc_pkg::OP_DIV_START;
         S_CLR: cmd.op = slc_pkg::OP_CLEAR;
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cls_ff <= '0;
         fin_ff <= 1'b0;
         rsp_valid <= 1'b0;
         rsp_last <= 1'b0;
         rsp_class <= '0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (accept && mode) begin
               cls_ff <= '0;
               fin_ff <= final_feature;
               state_ff <= (32'(position) < FEATURES) ? S_MAC : S_DRAIN;
            end
            S_MAC: begin
               cls_ff <= cls_ff + 6'd1;
               if (32'(cls_ff) == CLASSES - 1) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               cls_ff <= '0;
               state_ff <= fin_ff ? S_MAX : S_IDLE;
            end
            S_MAX: begin
               if (32'(cls_ff) == CLASSES - 1) begin
                  cls_ff <= '0;
                  state_ff <= S_EXP;
               end else cls_ff <= cls_ff + 6'd1;
            end
            S_EXP: begin
               if (32'(cls_ff) == CLASSES - 1) begin
                  cls_ff <= '0;
                  state_ff <= S_EXPW;
               end else cls_ff <= cls_ff + 6'd1;
            end
            // last exp value and the sum settle
            S_EXPW: state_ff <= S_DIV;
            S_DIV: state_ff <= S_WAIT;
            S_WAIT: if (status.div_done) begin
               rsp_valid <= 1'b1;
               rsp_class <= cls_ff[2:0];
               rsp_last <= (32'(cls_ff) == NREP - 1);
               cls_ff <= cls_ff + 6'd1;
               state_ff <= (32'(cls_ff) == NREP - 1) ? S_CLR : S_DIV;
            end
            S_CLR: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `SLC_ASSERT_IMP(a_no_accept_busy, clock, reset, accept, state_ff == S_IDLE, "accept while busy")
   `SLC_ASSERT_IMP(a_rsp_from_wait, clock, reset, rsp_valid, state_ff == S_DIV || state_ff == S_CLR, "stray")
   `SLC_ASSERT_IMP(a_done_in_wait, clock, reset, status.div_done, state_ff == S_WAIT, "divider done outside wait")
endmodule

/* hw/rtl/softmax_linear_classifier.sv */
// Softmax linear classifier top level.
// Depends on slc_pkg, slc_controller, slc_datapath and the macros header.
// Usage: drive req_* with start high; an item is transferred when start is
// high and busy is low. mode 0 writes a weight word at req_position (no
// result). mode 1 supplies a feature: the shared multiplier takes one
// class per cycle. With req_final_feature set, the block then scans the
// scores for the maximum, forms exp per class, and divides each by the sum
// with a bit-serial divider, giving up to 8 results.
// Each result appears for one cycle with rsp_valid high; rsp_last_class
// marks the final one. The receiver cannot stall the block.
// Reset clears control state, scores, exp values and the sum; the weight
// memory holds no defined value until written.
// Scores are cleared after each evaluation.
`timescale 1ns / 1ps
`include "softmax_linear_classifier_macros.svh"
module softmax_linear_classifier #(
   parameter int FEATURES = slc_pkg::FEATURES_DEFAULT,
   parameter int CLASSES  = slc_pkg::CLASSES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [8:0]         req_position,
   input  logic signed [15:0] req_value,
   input  logic               req_final_feature,
   output logic               rsp_valid,
   output logic [2:0]         rsp_class_number,
   output logic [15:0]        rsp_probability,
   output logic               rsp_last_class
);
   slc_pkg::dp_cmd_type cmd;
   slc_pkg::dp_status_type status;
   logic accept;

   assign accept = start && !busy;

   slc_controller #(.FEATURES(FEATURES), .CLASSES(CLASSES)) u_ctrl (
      .clock, .reset, .accept, .mode(req_mode), .position(req_position),
      .final_feature(req_final_feature), .status, .cmd, .busy,
      .rsp_valid, .rsp_class(rsp_class_number), .rsp_last(rsp_last_class)
   );

   slc_datapath #(.FEATURES(FEATURES), .CLASSES(CLASSES)) u_dp (
      .clock, .reset, .wr_en(accept && !req_mode), .load(accept && req_mode),
      .wr_addr(req_position), .feat(req_position), .value(req_value), .cmd, .status,
      .probability(rsp_probability)
   );

   `SLC_ASSERT_NEXT(a_busy_after_feature, clock, reset, accept && req_mode, busy, "feature not taken")
   `SLC_ASSERT_IMP(a_no_rsp_idle, clock, reset, rsp_valid, busy, "result while idle")
   `SLC_ASSERT_NEXT(a_write_no_busy, clock, reset, accept && !req_mode, !busy, "write held block")
endmodule
